### rtl/bba_pkg.sv
package bba_pkg;

   localparam int BITMAP_BYTES_DEF = 4096;
   localparam int INDEX_SPAN       = 32768;
   localparam logic [15:0] FREE_MAX = 16'd32768;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_ALLOC  = 2'd1;
   localparam logic [1:0] KIND_FREE   = 2'd2;
   localparam logic [1:0] KIND_SETCNT = 2'd3;

   function automatic logic [2:0] lowest_set(input logic [7:0] v);
      logic [2:0] idx;
      idx = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (v[j]) idx = 3'(j);
      end
      return idx;
   endfunction

endpackage

### rtl/bitmap_block_allocator.sv
// Sequencing: load, set count, empty allocate and out-of-range free give their result
//   word in the cycle after start; free reads the byte, then clears the bit in the FREE
//   state; allocate tests bitmap bytes in the SCAN state up to the first hit or range end.
// Throughput: busy drops in the cycle the result word shows; scan speed is set by
//   the single bitmap RAM read port, one byte per cycle. Receiver cannot stall.
// Reset: clears control and the free counter; bitmap RAM is not cleared.
module bitmap_block_allocator
   import bba_pkg::*;
#(
   parameter int BITMAP_BYTES = BITMAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [14:0] req_position,
   input  logic [15:0] req_limit,
   input  logic [7:0]  req_byte_data,
   input  logic [15:0] req_count_value,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [14:0] rsp_bit_index,
   output logic [15:0] rsp_free_count
);

   localparam int AW = $clog2(BITMAP_BYTES);
   localparam logic [15:0] END_MAX =
      16'((8 * BITMAP_BYTES < INDEX_SPAN) ? 8 * BITMAP_BYTES : INDEX_SPAN);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FREE = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [14:0] start_ff, start_in;
   logic [14:0] endm1_ff, endm1_in;
   logic [11:0] eval_ff, eval_in;
   logic [11:0] scan_ff, scan_in;
   logic [15:0] count_ff, count_in;
   logic        valid_ff, valid_in;
   logic        found_ff, found_in;
   logic [14:0] index_ff, index_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata, rdata;

   logic        accept;
   logic [15:0] end_c;
   logic        nonempty;
   logic [2:0]  lo, hi;
   logic [7:0]  mask, cand;
   logic        hit;
   logic [2:0]  hit_bit;

   bba_ram #(.WIDTH(8), .DEPTH(BITMAP_BYTES)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign end_c    = (req_limit > END_MAX) ? END_MAX : req_limit;
   assign nonempty = end_c > {1'b0, req_position};

   always_comb begin
      lo = (eval_ff == start_ff[14:3]) ? start_ff[2:0] : 3'd0;
      hi = (eval_ff == endm1_ff[14:3]) ? endm1_ff[2:0] : 3'd7;
      for (int j = 0; j < 8; j++) begin
         mask[j] = (3'(j) >= lo) && (3'(j) <= hi);
      end
      cand    = ~rdata & mask;
      hit     = |cand;
      hit_bit = lowest_set(cand);
   end

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      endm1_in = endm1_ff;
      eval_in  = eval_ff;
      scan_in  = scan_ff;
      count_in = count_ff;
      valid_in = 1'b0;
      found_in = found_ff;
      index_in = index_ff;
      we       = 1'b0;
      waddr    = AW'(req_position);
      wdata    = req_byte_data;
      raddr    = AW'(req_position[14:3]);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in = 1'b1;
               found_in = 1'b0;
               index_in = 15'd0;
               unique case (req_kind)
                  KIND_LOAD: begin
                     we = 32'(req_position) < BITMAP_BYTES;
                  end
                  KIND_ALLOC: begin
                     if (nonempty) begin
                        valid_in = 1'b0;
                        state_in = ST_SCAN;
                        start_in = req_position;
                        endm1_in = 15'(end_c - 16'd1);
                        eval_in  = req_position[14:3];
                        scan_in  = req_position[14:3] + 12'd1;
                     end
                  end
                  KIND_FREE: begin
                     if (32'(req_position[14:3]) < BITMAP_BYTES) begin
                        valid_in = 1'b0;
                        state_in = ST_FREE;
                        start_in = req_position;
                     end
                  end
                  KIND_SETCNT: begin
                     count_in = (req_count_value > FREE_MAX) ? FREE_MAX : req_count_value;
                  end
               endcase
            end
         end
         ST_FREE: begin
            we       = 1'b1;
            waddr    = AW'(start_ff[14:3]);
            wdata    = rdata & ~(8'd1 << start_ff[2:0]);
            count_in = (count_ff < FREE_MAX) ? count_ff + 16'd1 : count_ff;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            raddr = AW'(scan_ff);
            if (hit) begin
               we       = 1'b1;
               waddr    = AW'(eval_ff);
               wdata    = rdata | (8'd1 << hit_bit);
               count_in = (count_ff != 16'd0) ? count_ff - 16'd1 : count_ff;
               found_in = 1'b1;
               index_in = {eval_ff, hit_bit};
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (eval_ff == endm1_ff[14:3]) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               eval_in = scan_ff;
               scan_in = scan_ff + 12'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 16'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      start_ff <= start_in;
      endm1_ff <= endm1_in;
      eval_ff  <= eval_in;
      scan_ff  <= scan_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_bit_index  = index_ff;
   assign rsp_free_count = count_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (state_ff == ST_IDLE))
      else $error("result word while engine busy");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FREE_MAX)
      else $error("free count above maximum");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (eval_ff <= endm1_ff[14:3]))
      else $error("scan ran past range end");

   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff == eval_ff + 12'd1))
      else $error("scan read address out of step");

endmodule

### rtl/bba_ram.sv
module bba_ram
   import bba_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = BITMAP_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule

### tb/sv/bitmap_block_allocator_checker.sv
`timescale 1ns / 100ps

module bitmap_block_allocator_checker
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [14:0] req_position,
   input  logic [15:0] req_limit,
   input  logic [7:0]  req_byte_data,
   input  logic [15:0] req_count_value,
   input  logic        rsp_valid,
   input  logic        rsp_found,
   input  logic [14:0] rsp_bit_index,
   input  logic [15:0] rsp_free_count,
   output int          pending_words,
   output int          error_count
);

   typedef struct packed {
      logic        found;
      logic [14:0] bit_index;
      logic [15:0] free_count;
   } alloc_outcome_type;

   logic [7:0]        shadow_bitmap [BITMAP_BYTES_DEF];
   logic [15:0]       shadow_free;
   alloc_outcome_type outcome_fifo [$];

   initial begin
      pending_words = 0;
      error_count = 0;
      shadow_free = '0;
   end

   always @(posedge clock) begin
      alloc_outcome_type oldest;
      alloc_outcome_type next_word;
      int search_end;
      int b;
      if (reset) begin
         outcome_fifo.delete();
         shadow_free = '0;
      end else begin
         if (rsp_valid) begin
            if (outcome_fifo.size() == 0) begin
               $error("result word with no request outstanding");
               error_count++;
            end else begin
               oldest = outcome_fifo.pop_front();
               if (rsp_found !== oldest.found) begin
                  $error("found: expected %0d, got %0d", oldest.found, rsp_found);
                  error_count++;
               end
               if (rsp_bit_index !== oldest.bit_index) begin
                  $error("bit_index: expected %0d, got %0d", oldest.bit_index, rsp_bit_index);
                  error_count++;
               end
               if (rsp_free_count !== oldest.free_count) begin
                  $error("free_count: expected %0d, got %0d",
                         oldest.free_count, rsp_free_count);
                  error_count++;
               end
            end
         end

         if (start && !busy) begin
            next_word = '0;
            case (req_kind)
               KIND_LOAD: begin
                  if (int'(req_position) < BITMAP_BYTES_DEF)
                     shadow_bitmap[req_position] = req_byte_data;
               end
               KIND_ALLOC: begin
                  search_end = int'(req_limit);
                  if (search_end > 8 * BITMAP_BYTES_DEF) search_end = 8 * BITMAP_BYTES_DEF;
                  if (search_end > INDEX_SPAN) search_end = INDEX_SPAN;
                  for (b = int'(req_position); b < search_end && !next_word.found; b++) begin
                     if (!shadow_bitmap[b >> 3][b % 8]) begin
                        next_word.found = 1'b1;
                        next_word.bit_index = 15'(b);
                     end
                  end
                  if (next_word.found) begin
                     shadow_bitmap[next_word.bit_index >> 3][next_word.bit_index[2:0]] = 1'b1;
                     if (shadow_free != 0) shadow_free = shadow_free - 16'd1;
                  end
               end
               KIND_FREE: begin
                  if (int'(req_position >> 3) < BITMAP_BYTES_DEF) begin
                     shadow_bitmap[req_position >> 3][req_position[2:0]] = 1'b0;
                     if (shadow_free < FREE_MAX) shadow_free = shadow_free + 16'd1;
                  end
               end
               default: begin
                  shadow_free = (req_count_value > FREE_MAX) ? FREE_MAX : req_count_value;
               end
            endcase
            next_word.free_count = shadow_free;
            outcome_fifo.push_back(next_word);
         end
      end
      pending_words = outcome_fifo.size();
   end

endmodule

### tb/sv/bitmap_block_allocator_tb.sv
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;
   import bba_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_WORDS = 650;
   localparam int DRAIN_CYCLES = 40;
   localparam int WINDOW_BYTES = 128;
   localparam int WINDOW_BITS  = 8 * WINDOW_BYTES;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [14:0] req_position;
   logic [15:0] req_limit;
   logic [7:0]  req_byte_data;
   logic [15:0] req_count_value;
   logic        rsp_valid;
   logic        rsp_found;
   logic [14:0] rsp_bit_index;
   logic [15:0] rsp_free_count;
   int          pending_words;
   int          error_count;
   int          burst_left;

   bitmap_block_allocator uut (.*);

   bitmap_block_allocator_checker outcome_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic int pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 8'hFF;
      if (r == 5) return 8'h00;
      return $urandom_range(0, 255);
   endfunction

   task automatic send_word(input logic [1:0] kind, input int position, input int limit,
                            input int byte_data, input int count_value);
      int gap;
      @(negedge clock);
      start = 1'b1;
      req_kind = kind;
      req_position = 15'(position);
      req_limit = 16'(limit);
      req_byte_data = 8'(byte_data);
      req_count_value = 16'(count_value);
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // hold off until every outstanding word has returned
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   initial begin
      int sel;
      int r;
      int position;
      int span;
      int limit;
      int value;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_LOAD;
      req_position = '0;
      req_limit = '0;
      req_byte_data = '0;
      req_count_value = '0;
      burst_left = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // low window of the bitmap gets defined contents, mostly full bytes;
      // random searches and frees stay inside it
      for (int a = 0; a < WINDOW_BYTES; a++)
         send_word(KIND_LOAD, a, $urandom_range(0, 32768), pick_byte(),
                   $urandom_range(0, 32768));
      settle();

      send_word(KIND_SETCNT, 0, 0, 0, 0);
      send_word(KIND_ALLOC, 0, 0, 0, 0);
      send_word(KIND_ALLOC, 100, 50, 0, 0);
      send_word(KIND_LOAD, 0, 0, 8'hFE, 0);
      send_word(KIND_ALLOC, 0, 8, 0, 0);
      send_word(KIND_SETCNT, 0, 0, 0, 16'hFFFF);
      send_word(KIND_FREE, 0, 0, 0, 0);
      send_word(KIND_SETCNT, 0, 0, 0, 100);
      send_word(KIND_FREE, 0, 0, 0, 0);
      send_word(KIND_LOAD, 2, 0, 8'hEF, 0);
      send_word(KIND_LOAD, 3, 0, 8'hFF, 0);
      send_word(KIND_ALLOC, 19, 40, 0, 0);
      send_word(KIND_LOAD, 4, 0, 8'hFF, 0);
      send_word(KIND_LOAD, 5, 0, 8'hFF, 0);
      send_word(KIND_LOAD, 6, 0, 8'hBF, 0);
      send_word(KIND_ALLOC, 32, 54, 0, 0);
      send_word(KIND_ALLOC, 32, 55, 0, 0);
      send_word(KIND_LOAD, BITMAP_BYTES_DEF, 0, 8'h00, 0);
      send_word(KIND_LOAD, 32767, 0, 8'h00, 0);
      send_word(KIND_LOAD, BITMAP_BYTES_DEF - 1, 0, 8'h7F, 0);
      send_word(KIND_ALLOC, 32760, 32768, 0, 0);
      send_word(KIND_ALLOC, 32767, 16'hFFFF, 0, 0);
      send_word(KIND_FREE, 32767, 0, 0, 0);
      send_word(KIND_LOAD, 1, 0, 8'h00, 0);
      send_word(KIND_ALLOC, 1, 32768, 0, 0);
      settle();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         sel = $urandom_range(0, 99);
         position = $urandom_range(0, WINDOW_BITS - 1);
         if (sel < 45) begin
            if ($urandom_range(0, 3) == 0) position = position & ~7;
            r = $urandom_range(0, 99);
            if (r < 65) span = $urandom_range(1, 64);
            else if (r < 88) span = $urandom_range(65, 1024);
            else if (r < 94) span = 32768;
            else span = -int'($urandom_range(0, 64));
            limit = position + span;
            if (limit > WINDOW_BITS) limit = WINDOW_BITS;
            if (limit < 0) limit = 0;
            send_word(KIND_ALLOC, position, limit, $urandom_range(0, 255),
                      $urandom_range(0, 32768));
         end else if (sel < 65) begin
            send_word(KIND_FREE, position, $urandom_range(0, 32768), $urandom_range(0, 255),
                      $urandom_range(0, 32768));
         end else if (sel < 87) begin
            if ($urandom_range(0, 9) != 0) position = $urandom_range(0, WINDOW_BYTES - 1);
            else position = $urandom_range(0, 32767);
            send_word(KIND_LOAD, position, $urandom_range(0, 32768), pick_byte(),
                      $urandom_range(0, 32768));
         end else begin
            r = $urandom_range(0, 9);
            case (r)
               0: value = 0;
               1: value = 1;
               2: value = 32767;
               3: value = 32768;
               4: value = 16'hFFFF;
               default: value = $urandom_range(0, 32768);
            endcase
            send_word(KIND_SETCNT, position, $urandom_range(0, 32768), $urandom_range(0, 255),
                      value);
         end
         if (n % 100 == 99) settle();
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### bitmap_block_allocator.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bitmap_block_allocator.sv
tb/sv/bitmap_block_allocator_checker.sv
tb/sv/bitmap_block_allocator_tb.sv
